>>> design/transaction_state_tracker_defines.svh
// Assertion macros for the transaction state tracker checker.
// No dependencies; include by bare file name.
`ifndef TRANSACTION_STATE_TRACKER_DEFINES_SVH
`define TRANSACTION_STATE_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/tst_pkg.sv
// Shared types and constants for the transaction state tracker.
// No dependencies.
`default_nettype none

package tst_pkg;

   localparam int unsigned SLOT_W         = 10;
   localparam int unsigned KIND_W         = 3;
   localparam int unsigned STAGE_W        = 3;
   localparam int unsigned STATE_W        = 5;
   localparam int unsigned STEP_W         = 5;
   localparam int unsigned SLOT_COUNT_DEF = 1024;
   localparam int unsigned TIME_BITS_DEF  = 48;

   // controller -> datapath
   typedef struct packed {
      logic clear;    // zero one state entry and advance the sweep
      logic capture;  // latch request and read the slot tables
      logic commit;   // write back and load the result register
   } tst_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;  // sweep is at the final entry
      logic rsp_stall;   // result register full and not being taken
   } tst_status_type;

endpackage

`default_nettype wire

>>> design/tst_ctrl.sv
// Sequencing state machine for the transaction state tracker.
// Depends on tst_pkg.
`default_nettype none

module tst_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire tst_pkg::tst_status_type status,
   output tst_pkg::tst_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } tst_fsm_type;

   tst_fsm_type state_ff;
   tst_fsm_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.clear   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the result register can take the item
            if (!status.rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> design/tst_datapath.sv
// Slot tables, transition rules and result register of the state tracker.
// Depends on tst_pkg.
`default_nettype none

module tst_datapath #(
   parameter int unsigned SLOT_COUNT = tst_pkg::SLOT_COUNT_DEF,
   parameter int unsigned TIME_BITS  = tst_pkg::TIME_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tst_pkg::tst_cmd_type         cmd,
   output tst_pkg::tst_status_type           status,
   input  wire logic [tst_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [tst_pkg::KIND_W-1:0]   req_packet_kind,
   input  wire logic [tst_pkg::STAGE_W-1:0]  req_stage,
   input  wire logic [TIME_BITS-1:0]         req_now_time,
   input  wire logic                         rsp_ready,
   output logic                              rsp_valid,
   output logic [tst_pkg::STATE_W-1:0]       rsp_new_state,
   output logic                              rsp_bad_transition,
   output logic                              rsp_step_valid,
   output logic [tst_pkg::STEP_W-1:0]        rsp_step_kind,
   output logic [TIME_BITS-1:0]              rsp_step_latency,
   output logic                              rsp_total_valid,
   output logic [TIME_BITS-1:0]              rsp_total_latency
);

   localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
   localparam int unsigned SW    = tst_pkg::STATE_W;
   localparam int unsigned KW    = tst_pkg::STEP_W;

   // packet kinds
   localparam logic [2:0] PK_PULL_REQ = 3'd0, PK_PULL_DATA = 3'd1, PK_PUSH_REQ = 3'd2,
                          PK_GRANT = 3'd3, PK_SOL_DATA = 3'd4, PK_UNSOL_DATA = 3'd5,
                          PK_RESYNC = 3'd6;
   // processing stages
   localparam logic [2:0] SG_ULP_RX = 3'd0, SG_ULP_TX = 3'd1, SG_ULP_ACK_RX = 3'd2,
                          SG_ULP_CMPL_TX = 3'd3, SG_NET_RX = 3'd4, SG_NET_TX = 3'd5,
                          SG_NET_ACK_RX = 3'd6, SG_ULP_RNR_RX = 3'd7;
   // slot lifecycle states
   localparam logic [SW-1:0]
      S_PQ_ULPRX = 5'd1,  S_PQ_ULPTX = 5'd2,  S_PQ_ACKRX = 5'd3,  S_PQ_NETRX = 5'd4,
      S_PQ_NETTX = 5'd5,  S_PQ_RNR = 5'd6,    S_PD_ULPRX = 5'd7,  S_PD_ULPTX = 5'd8,
      S_PD_NETRX = 5'd9,  S_PD_NETTX = 5'd10, S_PD_ACKRX = 5'd11, S_SQ_ULPRX = 5'd12,
      S_HQ_NETRX = 5'd13, S_HQ_NETTX = 5'd14, S_GR_NETRX = 5'd15, S_GR_NETTX = 5'd16,
      S_SD_ULPTX = 5'd17, S_SD_ACKULP = 5'd18, S_PUSH_DONE = 5'd19, S_SD_NETRX = 5'd20,
      S_SD_NETTX = 5'd21, S_SD_ACKNET = 5'd22, S_SD_RNR = 5'd23, S_UQ_ULPRX = 5'd24,
      S_UD_ULPTX = 5'd25, S_UD_ACKULP = 5'd26, S_UD_NETRX = 5'd27, S_UD_NETTX = 5'd28,
      S_UD_ACKNET = 5'd29, S_UD_RNR = 5'd30, S_RESYNC = 5'd31;
   // step latency categories
   localparam logic [KW-1:0]
      K_PULL_NREQ_UREQ = 5'd0,  K_PULL_UREQ_ACK = 5'd1,  K_PULL_ACK_DATA = 5'd2,
      K_PULL_NDATA_UTX = 5'd3,  K_PULL_NREQ_NDATA = 5'd4, K_PULL_UDATA_NTX = 5'd5,
      K_PULL_NTX_ACK = 5'd6,    K_PULL_UREQ_NTX = 5'd7,  K_SOL_ULP_NTX = 5'd8,
      K_SOL_REQ_GRANT = 5'd9,   K_SOL_REQRX_GTX = 5'd10, K_SOL_NDATA_UTX = 5'd11,
      K_SOL_UTX_ACK = 5'd12,    K_SOL_ACK_DONE = 5'd13,  K_SOL_GTX_DATA = 5'd14,
      K_SOL_GRX_DTX = 5'd15,    K_SOL_DTX_ACK = 5'd16,   K_UNS_NDATA_UTX = 5'd17,
      K_UNS_UTX_ACK = 5'd18,    K_UNS_ACK_DONE = 5'd19,  K_UNS_ULP_NTX = 5'd20,
      K_UNS_DTX_ACK = 5'd21;

   typedef struct packed {
      logic          ok;
      logic          touch;
      logic          start;
      logic          total;
      logic          has_step;
      logic [KW-1:0] step;
      logic [SW-1:0] next;
   } tst_move_type;

   function automatic tst_move_type decide(input logic [SW-1:0] cur,
                                           input logic [2:0] kind,
                                           input logic [2:0] stage);
      tst_move_type m;
      m.ok       = 1'b1;
      m.touch    = 1'b1;
      m.start    = 1'b0;
      m.total    = 1'b0;
      m.has_step = 1'b0;
      m.step     = '0;
      m.next     = cur;
      unique case ({kind, stage})
         {PK_PULL_REQ, SG_ULP_RX}: begin
            m.next = S_PQ_ULPRX; m.start = 1'b1;
         end
         {PK_PULL_REQ, SG_ULP_TX}: begin
            m.ok = (cur == S_PQ_NETRX) || (cur == S_PQ_RNR);
            m.next = S_PQ_ULPTX; m.has_step = 1'b1; m.step = K_PULL_NREQ_UREQ;
         end
         {PK_PULL_REQ, SG_ULP_ACK_RX}: begin
            m.ok = (cur == S_PQ_ULPTX);
            m.next = S_PQ_ACKRX; m.has_step = 1'b1; m.step = K_PULL_UREQ_ACK;
         end
         {PK_PULL_REQ, SG_NET_RX}: begin
            m.next = S_PQ_NETRX;
         end
         {PK_PULL_REQ, SG_NET_TX}: begin
            m.ok = (cur == S_PQ_ULPRX);
            m.next = S_PQ_NETTX; m.has_step = 1'b1; m.step = K_PULL_UREQ_NTX;
         end
         {PK_PULL_REQ, SG_NET_ACK_RX}: begin
            m.touch = 1'b0;
         end
         {PK_PULL_REQ, SG_ULP_RNR_RX}: begin
            m.ok = (cur == S_PQ_ULPTX) || (cur == S_PQ_NETRX);
            m.next = S_PQ_RNR;
         end
         {PK_PULL_DATA, SG_ULP_RX}: begin
            m.ok = (cur == S_PQ_ACKRX);
            m.next = S_PD_ULPRX; m.has_step = 1'b1; m.step = K_PULL_ACK_DATA;
         end
         {PK_PULL_DATA, SG_ULP_TX}: begin
            m.ok = (cur == S_PD_NETRX);
            m.next = S_PD_ULPTX; m.has_step = 1'b1; m.step = K_PULL_NDATA_UTX;
            m.total = 1'b1;
         end
         {PK_PULL_DATA, SG_NET_RX}: begin
            m.ok = (cur == S_PQ_NETTX);
            m.next = S_PD_NETRX; m.has_step = 1'b1; m.step = K_PULL_NREQ_NDATA;
         end
         {PK_PULL_DATA, SG_NET_TX}: begin
            m.ok = (cur == S_PD_ULPRX);
            m.next = S_PD_NETTX; m.has_step = 1'b1; m.step = K_PULL_UDATA_NTX;
         end
         {PK_PULL_DATA, SG_NET_ACK_RX}: begin
            m.ok = (cur == S_PD_NETTX);
            m.next = S_PD_ACKRX; m.has_step = 1'b1; m.step = K_PULL_NTX_ACK;
         end
         {PK_PUSH_REQ, SG_ULP_RX}: begin
            m.next = S_SQ_ULPRX; m.start = 1'b1;
         end
         {PK_PUSH_REQ, SG_NET_RX}: begin
            m.next = S_HQ_NETRX;
         end
         {PK_PUSH_REQ, SG_NET_TX}: begin
            m.ok = (cur == S_SQ_ULPRX);
            m.next = S_HQ_NETTX; m.has_step = 1'b1; m.step = K_SOL_ULP_NTX;
         end
         {PK_PUSH_REQ, SG_NET_ACK_RX}: begin
            m.touch = 1'b0;
         end
         {PK_GRANT, SG_NET_RX}: begin
            m.ok = (cur == S_HQ_NETTX);
            m.next = S_GR_NETRX; m.has_step = 1'b1; m.step = K_SOL_REQ_GRANT;
         end
         {PK_GRANT, SG_NET_TX}: begin
            m.ok = (cur == S_HQ_NETRX);
            m.next = S_GR_NETTX; m.has_step = 1'b1; m.step = K_SOL_REQRX_GTX;
         end
         {PK_GRANT, SG_NET_ACK_RX}: begin
            m.touch = 1'b0;
         end
         {PK_SOL_DATA, SG_ULP_TX}: begin
            m.ok = (cur == S_SD_NETRX) || (cur == S_SD_RNR);
            m.next = S_SD_ULPTX; m.has_step = 1'b1; m.step = K_SOL_NDATA_UTX;
         end
         {PK_SOL_DATA, SG_ULP_ACK_RX}: begin
            m.ok = (cur == S_SD_ULPTX);
            m.next = S_SD_ACKULP; m.has_step = 1'b1; m.step = K_SOL_UTX_ACK;
         end
         {PK_SOL_DATA, SG_ULP_CMPL_TX}: begin
            m.ok = (cur == S_SD_ACKNET);
            m.next = S_PUSH_DONE; m.has_step = 1'b1; m.step = K_SOL_ACK_DONE;
            m.total = 1'b1;
         end
         {PK_SOL_DATA, SG_NET_RX}: begin
            m.ok = (cur == S_GR_NETTX);
            m.next = S_SD_NETRX; m.has_step = 1'b1; m.step = K_SOL_GTX_DATA;
         end
         {PK_SOL_DATA, SG_NET_TX}: begin
            m.ok = (cur == S_GR_NETRX);
            m.next = S_SD_NETTX; m.has_step = 1'b1; m.step = K_SOL_GRX_DTX;
         end
         {PK_SOL_DATA, SG_NET_ACK_RX}: begin
            m.ok = (cur == S_SD_NETTX);
            m.next = S_SD_ACKNET; m.has_step = 1'b1; m.step = K_SOL_DTX_ACK;
         end
         {PK_SOL_DATA, SG_ULP_RNR_RX}: begin
            m.ok = (cur == S_SD_ULPTX) || (cur == S_SD_NETRX);
            m.next = S_SD_RNR;
         end
         {PK_UNSOL_DATA, SG_ULP_RX}: begin
            m.next = S_UQ_ULPRX; m.start = 1'b1;
         end
         {PK_UNSOL_DATA, SG_ULP_TX}: begin
            m.ok = (cur == S_UD_NETRX) || (cur == S_UD_RNR);
            m.next = S_UD_ULPTX; m.has_step = 1'b1; m.step = K_UNS_NDATA_UTX;
         end
         {PK_UNSOL_DATA, SG_ULP_ACK_RX}: begin
            m.ok = (cur == S_UD_ULPTX);
            m.next = S_UD_ACKULP; m.has_step = 1'b1; m.step = K_UNS_UTX_ACK;
         end
         {PK_UNSOL_DATA, SG_ULP_CMPL_TX}: begin
            m.ok = (cur == S_UD_ACKNET);
            m.next = S_PUSH_DONE; m.has_step = 1'b1; m.step = K_UNS_ACK_DONE;
            m.total = 1'b1;
         end
         {PK_UNSOL_DATA, SG_NET_RX}: begin
            m.next = S_UD_NETRX;
         end
         {PK_UNSOL_DATA, SG_NET_TX}: begin
            m.ok = (cur == S_UQ_ULPRX);
            m.next = S_UD_NETTX; m.has_step = 1'b1; m.step = K_UNS_ULP_NTX;
         end
         {PK_UNSOL_DATA, SG_NET_ACK_RX}: begin
            m.ok = (cur == S_UD_NETTX);
            m.next = S_UD_ACKNET; m.has_step = 1'b1; m.step = K_UNS_DTX_ACK;
         end
         {PK_UNSOL_DATA, SG_ULP_RNR_RX}: begin
            m.ok = (cur == S_UD_ULPTX) || (cur == S_UD_NETRX);
            m.next = S_UD_RNR;
         end
         {PK_RESYNC, SG_NET_RX}: begin
            m.next = S_RESYNC;
         end
         default: begin
            m.ok = 1'b0;
         end
      endcase
      return m;
   endfunction

   // slot tables
   logic [SW-1:0]        state_mem [SLOT_COUNT];
   logic [TIME_BITS-1:0] last_mem  [SLOT_COUNT];
   logic [TIME_BITS-1:0] start_mem [SLOT_COUNT];

   logic [IDX_W-1:0]     clr_cnt_ff;
   logic [IDX_W-1:0]     clr_cnt_in;

   // captured request and table read data
   logic [IDX_W-1:0]     idx_ff;
   logic                 in_range_ff;
   logic [2:0]           kind_ff;
   logic [2:0]           stage_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [SW-1:0]        state_rd_ff;
   logic [TIME_BITS-1:0] last_rd_ff;
   logic [TIME_BITS-1:0] start_rd_ff;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [SW-1:0]        new_state_ff;
   logic [SW-1:0]        new_state_in;
   logic                 bad_ff;
   logic                 bad_in;
   logic                 step_valid_ff;
   logic                 step_valid_in;
   logic [KW-1:0]        step_kind_ff;
   logic [KW-1:0]        step_kind_in;
   logic [TIME_BITS-1:0] step_lat_ff;
   logic [TIME_BITS-1:0] step_lat_in;
   logic                 total_valid_ff;
   logic                 total_valid_in;
   logic [TIME_BITS-1:0] total_lat_ff;
   logic [TIME_BITS-1:0] total_lat_in;

   logic [IDX_W-1:0]     req_idx;
   logic                 req_in_range;
   tst_move_type         mv;
   logic                 wr_en;

   assign req_idx      = IDX_W'(req_slot);
   assign req_in_range = 32'(req_slot) < 32'(SLOT_COUNT);
   assign mv           = decide(state_rd_ff, kind_ff, stage_ff);
   assign wr_en        = cmd.commit && in_range_ff && mv.ok && mv.touch;
   assign clr_cnt_in   = clr_cnt_ff + IDX_W'(1);

   assign status.clear_last = (clr_cnt_ff == IDX_W'(SLOT_COUNT - 1));
   assign status.rsp_stall  = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // state table: one write port shared by the sweep and write-back
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         state_mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         state_mem[idx_ff] <= mv.next;
      end
      if (cmd.capture) begin
         state_rd_ff <= state_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_mem[idx_ff] <= now_ff;
      end
      if (cmd.capture) begin
         last_rd_ff <= last_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && mv.start) begin
         start_mem[idx_ff] <= now_ff;
      end
      if (cmd.capture) begin
         start_rd_ff <= start_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff      <= req_idx;
         in_range_ff <= req_in_range;
         kind_ff     <= req_packet_kind;
         stage_ff    <= req_stage;
         now_ff      <= req_now_time;
      end
   end

   always_comb begin
      new_state_in   = '0;
      bad_in         = 1'b1;
      step_valid_in  = 1'b0;
      step_kind_in   = '0;
      step_lat_in    = '0;
      total_valid_in = 1'b0;
      total_lat_in   = '0;
      if (in_range_ff) begin
         new_state_in = state_rd_ff;
         if (mv.ok) begin
            bad_in = 1'b0;
            if (mv.touch) begin
               new_state_in = mv.next;
            end
            if (mv.has_step) begin
               step_valid_in = 1'b1;
               step_kind_in  = mv.step;
               step_lat_in   = now_ff - last_rd_ff;
            end
            if (mv.total) begin
               total_valid_in = 1'b1;
               total_lat_in   = now_ff - start_rd_ff;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         new_state_ff   <= new_state_in;
         bad_ff         <= bad_in;
         step_valid_ff  <= step_valid_in;
         step_kind_ff   <= step_kind_in;
         step_lat_ff    <= step_lat_in;
         total_valid_ff <= total_valid_in;
         total_lat_ff   <= total_lat_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_new_state      = new_state_ff;
   assign rsp_bad_transition = bad_ff;
   assign rsp_step_valid     = step_valid_ff;
   assign rsp_step_kind      = step_kind_ff;
   assign rsp_step_latency   = step_lat_ff;
   assign rsp_total_valid    = total_valid_ff;
   assign rsp_total_latency  = total_lat_ff;

endmodule

`default_nettype wire

>>> design/transaction_state_tracker.sv
// Transaction state tracker top level: tst_ctrl sequences tst_datapath; uses tst_pkg.
// Result path: an accepted item is captured with the slot-table read, then committed
// once the result register is free; no new item is taken until the last one is committed.
// The next item is taken while a finished result waits in the output register.
// Reset: synchronous; a clearing pass then zeroes the state table, one slot a cycle,
// with req_ready low until every slot is cleared.
`default_nettype none

module transaction_state_tracker #(
   parameter int unsigned SLOT_COUNT = tst_pkg::SLOT_COUNT_DEF,
   parameter int unsigned TIME_BITS  = tst_pkg::TIME_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [tst_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [tst_pkg::KIND_W-1:0]   req_packet_kind,
   input  wire logic [tst_pkg::STAGE_W-1:0]  req_stage,
   input  wire logic [TIME_BITS-1:0]         req_now_time,
   // result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [tst_pkg::STATE_W-1:0]       rsp_new_state,
   output logic                              rsp_bad_transition,
   output logic                              rsp_step_valid,
   output logic [tst_pkg::STEP_W-1:0]        rsp_step_kind,
   output logic [TIME_BITS-1:0]              rsp_step_latency,
   output logic                              rsp_total_valid,
   output logic [TIME_BITS-1:0]              rsp_total_latency
);

   // command and status between the sequencer and the datapath
   tst_pkg::tst_cmd_type    cmd;
   tst_pkg::tst_status_type status;

   // Sequencer: clear sweep after reset, then accept an item, then commit it
   // once the result register is free or being drained.
   tst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: slot tables, transition rules and the result register.
   // Slots at or above SLOT_COUNT answer as a bad transition with state zero.
   tst_datapath #(
      .SLOT_COUNT (SLOT_COUNT),
      .TIME_BITS  (TIME_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_slot           (req_slot),
      .req_packet_kind    (req_packet_kind),
      .req_stage          (req_stage),
      .req_now_time       (req_now_time),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_new_state      (rsp_new_state),
      .rsp_bad_transition (rsp_bad_transition),
      .rsp_step_valid     (rsp_step_valid),
      .rsp_step_kind      (rsp_step_kind),
      .rsp_step_latency   (rsp_step_latency),
      .rsp_total_valid    (rsp_total_valid),
      .rsp_total_latency  (rsp_total_latency)
   );

endmodule

`default_nettype wire

>>> design/tst_checker.sv
// Port-level checker for the transaction state tracker, bound to the top level.
// Depends on tst_pkg and transaction_state_tracker_defines.svh.
`default_nettype none
`include "transaction_state_tracker_defines.svh"

module tst_checker #(
   parameter int unsigned TIME_BITS = tst_pkg::TIME_BITS_DEF
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic [tst_pkg::SLOT_W-1:0]   req_slot,
   input wire logic [tst_pkg::KIND_W-1:0]   req_packet_kind,
   input wire logic [tst_pkg::STAGE_W-1:0]  req_stage,
   input wire logic [TIME_BITS-1:0]         req_now_time,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [tst_pkg::STATE_W-1:0]  rsp_new_state,
   input wire logic                         rsp_bad_transition,
   input wire logic                         rsp_step_valid,
   input wire logic [tst_pkg::STEP_W-1:0]   rsp_step_kind,
   input wire logic [TIME_BITS-1:0]         rsp_step_latency,
   input wire logic                         rsp_total_valid,
   input wire logic [TIME_BITS-1:0]         rsp_total_latency
);

   logic unused_req;
   assign unused_req = ^{req_slot, req_packet_kind, req_stage, req_now_time};

   // a stalled result holds
   `TST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_new_state) && $stable(rsp_step_latency) && $stable(rsp_total_latency),
      "result changed while stalled")

   // one item in flight: no accept right after an accept
   `TST_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready,
      !req_ready, "request taken while previous item still in work")

   // an illegal event produces no latency samples
   `TST_ASSERT_NOW(a_bad_no_sample, clock, reset, rsp_valid && rsp_bad_transition,
      !rsp_step_valid && !rsp_total_valid, "latency sample on a bad transition")

   // absent samples read as zero
   `TST_ASSERT_NOW(a_step_zero, clock, reset, rsp_valid && !rsp_step_valid,
      (rsp_step_kind == '0) && (rsp_step_latency == '0), "stale step sample")

   `TST_ASSERT_NOW(a_total_zero, clock, reset, rsp_valid && !rsp_total_valid,
      rsp_total_latency == '0, "stale total latency")

endmodule

bind transaction_state_tracker tst_checker #(.TIME_BITS(TIME_BITS)) u_tst_checker (.*);

`default_nettype wire

>>> sim/tb_transaction_state_tracker.sv
// Self-checking testbench for transaction_state_tracker: drives packet events,
// predicts each result with a scoreboard class and checks it field by field.
// Depends on tst_pkg and the transaction_state_tracker RTL.
`timescale 1ns / 1ps

module tb_transaction_state_tracker;

   localparam int unsigned SLOT_W  = tst_pkg::SLOT_W;
   localparam int unsigned STATE_W = tst_pkg::STATE_W;
   localparam int unsigned STEP_W  = tst_pkg::STEP_W;
   localparam int unsigned TIME_W  = tst_pkg::TIME_BITS_DEF;
   localparam int unsigned SLOTS   = tst_pkg::SLOT_COUNT_DEF;

   localparam int unsigned RANDOM_ITEMS = 1200;
   localparam int unsigned LANES        = 6;     // flows kept in flight at once
   localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int unsigned IDLE_PCT     = 17;
   // Covers the clearing pass after reset plus the long hold-off, several times over.
   localparam int unsigned QUIET_LIMIT  = 5000;

   localparam bit [TIME_W-1:0] T_MAX = '1;

   // Packet kinds
   localparam bit [2:0] PK_PULL_REQ   = 3'd0;
   localparam bit [2:0] PK_PULL_DATA  = 3'd1;
   localparam bit [2:0] PK_PUSH_REQ   = 3'd2;
   localparam bit [2:0] PK_GRANT      = 3'd3;
   localparam bit [2:0] PK_SOL_DATA   = 3'd4;
   localparam bit [2:0] PK_UNSOL_DATA = 3'd5;
   localparam bit [2:0] PK_RESYNC     = 3'd6;
   localparam bit [2:0] PK_OTHER      = 3'd7;

   // Processing stages
   localparam bit [2:0] SG_ULP_RX      = 3'd0;
   localparam bit [2:0] SG_ULP_TX      = 3'd1;
   localparam bit [2:0] SG_ULP_ACK_RX  = 3'd2;
   localparam bit [2:0] SG_ULP_CMPL_TX = 3'd3;
   localparam bit [2:0] SG_NET_RX      = 3'd4;
   localparam bit [2:0] SG_NET_TX      = 3'd5;
   localparam bit [2:0] SG_NET_ACK_RX  = 3'd6;
   localparam bit [2:0] SG_ULP_RNR_RX  = 3'd7;

   // Step latency categories; NO_STEP marks a move without a sample.
   localparam bit [4:0] STP_PULL_NETREQ_ULPTX   = 5'd0;
   localparam bit [4:0] STP_PULL_ULPTX_ACK      = 5'd1;
   localparam bit [4:0] STP_PULL_ACK_ULPDATA    = 5'd2;
   localparam bit [4:0] STP_PULL_NETDATA_ULPTX  = 5'd3;
   localparam bit [4:0] STP_PULL_REQTX_NETDATA  = 5'd4;
   localparam bit [4:0] STP_PULL_ULPDATA_NETTX  = 5'd5;
   localparam bit [4:0] STP_PULL_DATATX_ACK     = 5'd6;
   localparam bit [4:0] STP_PULL_ULPREQ_NETTX   = 5'd7;
   localparam bit [4:0] STP_SOL_ULP_NETREQ_TX   = 5'd8;
   localparam bit [4:0] STP_SOL_REQTX_GRANTRX   = 5'd9;
   localparam bit [4:0] STP_SOL_REQRX_GRANTTX   = 5'd10;
   localparam bit [4:0] STP_SOL_NETDATA_ULPTX   = 5'd11;
   localparam bit [4:0] STP_SOL_ULPTX_ACK       = 5'd12;
   localparam bit [4:0] STP_SOL_ACK_CMPL        = 5'd13;
   localparam bit [4:0] STP_SOL_GRANTTX_DATARX  = 5'd14;
   localparam bit [4:0] STP_SOL_GRANTRX_DATATX  = 5'd15;
   localparam bit [4:0] STP_SOL_DATATX_ACK      = 5'd16;
   localparam bit [4:0] STP_UNS_NETDATA_ULPTX   = 5'd17;
   localparam bit [4:0] STP_UNS_ULPTX_ACK       = 5'd18;
   localparam bit [4:0] STP_UNS_ACK_CMPL        = 5'd19;
   localparam bit [4:0] STP_UNS_ULP_NETDATA_TX  = 5'd20;
   localparam bit [4:0] STP_UNS_DATATX_ACK      = 5'd21;
   localparam bit [4:0] NO_STEP                 = 5'd31;

   typedef enum bit [STATE_W-1:0] {
      S_IDLE             = 5'd0,
      S_PREQ_ULP_RX      = 5'd1,
      S_PREQ_ULP_TX      = 5'd2,
      S_PREQ_ACK_ULP_RX  = 5'd3,
      S_PREQ_NET_RX      = 5'd4,
      S_PREQ_NET_TX      = 5'd5,
      S_PREQ_RNR         = 5'd6,
      S_PDATA_ULP_RX     = 5'd7,
      S_PDATA_ULP_TX     = 5'd8,
      S_PDATA_NET_RX     = 5'd9,
      S_PDATA_NET_TX     = 5'd10,
      S_PDATA_ACK_NET_RX = 5'd11,
      S_SREQ_ULP_RX      = 5'd12,
      S_PUSH_NET_RX      = 5'd13,
      S_PUSH_NET_TX      = 5'd14,
      S_GRANT_NET_RX     = 5'd15,
      S_GRANT_NET_TX     = 5'd16,
      S_SDATA_ULP_TX     = 5'd17,
      S_SDATA_ACK_ULP_RX = 5'd18,
      S_PUSH_CMPL        = 5'd19,
      S_SDATA_NET_RX     = 5'd20,
      S_SDATA_NET_TX     = 5'd21,
      S_SDATA_ACK_NET_RX = 5'd22,
      S_SDATA_RNR        = 5'd23,
      S_UREQ_ULP_RX      = 5'd24,
      S_UDATA_ULP_TX     = 5'd25,
      S_UDATA_ACK_ULP_RX = 5'd26,
      S_UDATA_NET_RX     = 5'd27,
      S_UDATA_NET_TX     = 5'd28,
      S_UDATA_ACK_NET_RX = 5'd29,
      S_UDATA_RNR        = 5'd30,
      S_RESYNC_NET_RX    = 5'd31
   } life_state_e;

   // Decision for one event against the current slot state.
   typedef struct {
      bit          legal;
      bit          touch;      // write state and last-update time
      bit          starts;     // also write the start time
      bit          completes;  // report total latency
      bit [4:0]    step;
      life_state_e next;
   } move_t;

   // One result item as seen on the rsp_ channel.
   typedef struct packed {
      logic [STATE_W-1:0] new_state;
      logic               bad_transition;
      logic               step_valid;
      logic [STEP_W-1:0]  step_kind;
      logic [TIME_W-1:0]  step_latency;
      logic               total_valid;
      logic [TIME_W-1:0]  total_latency;
   } outcome_t;

   // Holds a private copy of the slot table and the outcomes still owed by the block.
   class slot_lifecycle_scoreboard;
      life_state_e       slot_state [SLOTS];
      bit [TIME_W-1:0]   touched_at [SLOTS];
      bit [TIME_W-1:0]   started_at [SLOTS];
      outcome_t          pending_outcomes [$];
      int unsigned       mismatches;

      function new();
         foreach (slot_state[i]) begin
            slot_state[i] = S_IDLE;
            touched_at[i] = '0;
            started_at[i] = '0;
         end
         mismatches = 0;
      endfunction

      function void opener(inout move_t m, input life_state_e nx, input bit initiator);
         m.next   = nx;
         m.starts = initiator;
      endfunction

      function void advance_if(inout move_t m, input bit ok, input life_state_e nx,
                               input bit [4:0] stp);
         if (!ok) begin
            m.legal = 1'b0;
         end else begin
            m.next = nx;
            m.step = stp;
         end
      endfunction

      function move_t plan_move(life_state_e cur, bit [2:0] kind, bit [2:0] stage);
         move_t m;
         m = '{legal: 1'b1, touch: 1'b1, starts: 1'b0, completes: 1'b0,
               step: NO_STEP, next: cur};
         case ({kind, stage})
            // pull request
            {PK_PULL_REQ, SG_ULP_RX}:     opener(m, S_PREQ_ULP_RX, 1'b1);
            {PK_PULL_REQ, SG_ULP_TX}:     advance_if(m, cur inside {S_PREQ_NET_RX, S_PREQ_RNR},
                                                     S_PREQ_ULP_TX, STP_PULL_NETREQ_ULPTX);
            {PK_PULL_REQ, SG_ULP_ACK_RX}: advance_if(m, cur == S_PREQ_ULP_TX,
                                                     S_PREQ_ACK_ULP_RX, STP_PULL_ULPTX_ACK);
            {PK_PULL_REQ, SG_NET_RX}:     opener(m, S_PREQ_NET_RX, 1'b0);
            {PK_PULL_REQ, SG_NET_TX}:     advance_if(m, cur == S_PREQ_ULP_RX,
                                                     S_PREQ_NET_TX, STP_PULL_ULPREQ_NETTX);
            {PK_PULL_REQ, SG_ULP_RNR_RX}: advance_if(m, cur inside {S_PREQ_ULP_TX, S_PREQ_NET_RX},
                                                     S_PREQ_RNR, NO_STEP);
            // pull data
            {PK_PULL_DATA, SG_ULP_RX}:    advance_if(m, cur == S_PREQ_ACK_ULP_RX,
                                                     S_PDATA_ULP_RX, STP_PULL_ACK_ULPDATA);
            {PK_PULL_DATA, SG_ULP_TX}: begin
               advance_if(m, cur == S_PDATA_NET_RX, S_PDATA_ULP_TX, STP_PULL_NETDATA_ULPTX);
               m.completes = m.legal;
            end
            {PK_PULL_DATA, SG_NET_RX}:    advance_if(m, cur == S_PREQ_NET_TX,
                                                     S_PDATA_NET_RX, STP_PULL_REQTX_NETDATA);
            {PK_PULL_DATA, SG_NET_TX}:    advance_if(m, cur == S_PDATA_ULP_RX,
                                                     S_PDATA_NET_TX, STP_PULL_ULPDATA_NETTX);
            {PK_PULL_DATA, SG_NET_ACK_RX}: advance_if(m, cur == S_PDATA_NET_TX,
                                                      S_PDATA_ACK_NET_RX, STP_PULL_DATATX_ACK);
            // push request and grant
            {PK_PUSH_REQ, SG_ULP_RX}:     opener(m, S_SREQ_ULP_RX, 1'b1);
            {PK_PUSH_REQ, SG_NET_RX}:     opener(m, S_PUSH_NET_RX, 1'b0);
            {PK_PUSH_REQ, SG_NET_TX}:     advance_if(m, cur == S_SREQ_ULP_RX,
                                                     S_PUSH_NET_TX, STP_SOL_ULP_NETREQ_TX);
            {PK_GRANT, SG_NET_RX}:        advance_if(m, cur == S_PUSH_NET_TX,
                                                     S_GRANT_NET_RX, STP_SOL_REQTX_GRANTRX);
            {PK_GRANT, SG_NET_TX}:        advance_if(m, cur == S_PUSH_NET_RX,
                                                     S_GRANT_NET_TX, STP_SOL_REQRX_GRANTTX);
            // acks for requests and grants leave everything untouched
            {PK_PULL_REQ, SG_NET_ACK_RX},
            {PK_PUSH_REQ, SG_NET_ACK_RX},
            {PK_GRANT, SG_NET_ACK_RX}:    m.touch = 1'b0;
            // solicited data
            {PK_SOL_DATA, SG_ULP_TX}:     advance_if(m, cur inside {S_SDATA_NET_RX, S_SDATA_RNR},
                                                     S_SDATA_ULP_TX, STP_SOL_NETDATA_ULPTX);
            {PK_SOL_DATA, SG_ULP_ACK_RX}: advance_if(m, cur == S_SDATA_ULP_TX,
                                                     S_SDATA_ACK_ULP_RX, STP_SOL_ULPTX_ACK);
            {PK_SOL_DATA, SG_ULP_CMPL_TX}: begin
               advance_if(m, cur == S_SDATA_ACK_NET_RX, S_PUSH_CMPL, STP_SOL_ACK_CMPL);
               m.completes = m.legal;
            end
            {PK_SOL_DATA, SG_NET_RX}:     advance_if(m, cur == S_GRANT_NET_TX,
                                                     S_SDATA_NET_RX, STP_SOL_GRANTTX_DATARX);
            {PK_SOL_DATA, SG_NET_TX}:     advance_if(m, cur == S_GRANT_NET_RX,
                                                     S_SDATA_NET_TX, STP_SOL_GRANTRX_DATATX);
            {PK_SOL_DATA, SG_NET_ACK_RX}: advance_if(m, cur == S_SDATA_NET_TX,
                                                     S_SDATA_ACK_NET_RX, STP_SOL_DATATX_ACK);
            {PK_SOL_DATA, SG_ULP_RNR_RX}: advance_if(m, cur inside {S_SDATA_ULP_TX, S_SDATA_NET_RX},
                                                     S_SDATA_RNR, NO_STEP);
            // unsolicited data
            {PK_UNSOL_DATA, SG_ULP_RX}:   opener(m, S_UREQ_ULP_RX, 1'b1);
            {PK_UNSOL_DATA, SG_ULP_TX}:   advance_if(m, cur inside {S_UDATA_NET_RX, S_UDATA_RNR},
                                                     S_UDATA_ULP_TX, STP_UNS_NETDATA_ULPTX);
            {PK_UNSOL_DATA, SG_ULP_ACK_RX}: advance_if(m, cur == S_UDATA_ULP_TX,
                                                       S_UDATA_ACK_ULP_RX, STP_UNS_ULPTX_ACK);
            {PK_UNSOL_DATA, SG_ULP_CMPL_TX}: begin
               advance_if(m, cur == S_UDATA_ACK_NET_RX, S_PUSH_CMPL, STP_UNS_ACK_CMPL);
               m.completes = m.legal;
            end
            {PK_UNSOL_DATA, SG_NET_RX}:   opener(m, S_UDATA_NET_RX, 1'b0);
            {PK_UNSOL_DATA, SG_NET_TX}:   advance_if(m, cur == S_UREQ_ULP_RX,
                                                     S_UDATA_NET_TX, STP_UNS_ULP_NETDATA_TX);
            {PK_UNSOL_DATA, SG_NET_ACK_RX}: advance_if(m, cur == S_UDATA_NET_TX,
                                                       S_UDATA_ACK_NET_RX, STP_UNS_DATATX_ACK);
            {PK_UNSOL_DATA, SG_ULP_RNR_RX}: advance_if(m, cur inside {S_UDATA_ULP_TX,
                                                       S_UDATA_NET_RX}, S_UDATA_RNR, NO_STEP);
            {PK_RESYNC, SG_NET_RX}:       opener(m, S_RESYNC_NET_RX, 1'b0);
            // no rule for the pair, including every event of the other kind
            default:                      m.legal = 1'b0;
         endcase
         return m;
      endfunction

      // Apply an accepted event to the table and queue the outcome it owes.
      // The 10-bit slot index never reaches past the table, so no range case exists.
      function void take_event(bit [SLOT_W-1:0] slot, bit [2:0] kind, bit [2:0] stage,
                               bit [TIME_W-1:0] now_ns);
         life_state_e cur;
         move_t       m;
         outcome_t    o;
         cur = slot_state[slot];
         m   = plan_move(cur, kind, stage);
         o   = '0;
         o.new_state      = cur;
         o.bad_transition = !m.legal;
         if (m.legal) begin
            if (m.step != NO_STEP) begin
               o.step_valid   = 1'b1;
               o.step_kind    = m.step;
               o.step_latency = now_ns - touched_at[slot];
            end
            if (m.completes) begin
               o.total_valid   = 1'b1;
               o.total_latency = now_ns - started_at[slot];
            end
            if (m.touch) begin
               slot_state[slot] = m.next;
               touched_at[slot] = now_ns;
               if (m.starts) started_at[slot] = now_ns;
               o.new_state = m.next;
            end
         end
         pending_outcomes.push_back(o);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_outcome(outcome_t seen);
         outcome_t want;
         if (pending_outcomes.size() == 0) begin
            $error("result item with no outstanding event");
            mismatches++;
            return;
         end
         want = pending_outcomes.pop_front();
         compare_field("new_state",      want.new_state,      seen.new_state);
         compare_field("bad_transition", want.bad_transition, seen.bad_transition);
         compare_field("step_valid",     want.step_valid,     seen.step_valid);
         compare_field("step_kind",      want.step_kind,      seen.step_kind);
         compare_field("step_latency",   want.step_latency,   seen.step_latency);
         compare_field("total_valid",    want.total_valid,    seen.total_valid);
         compare_field("total_latency",  want.total_latency,  seen.total_latency);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [SLOT_W-1:0]    req_slot;
   logic [2:0]           req_packet_kind;
   logic [2:0]           req_stage;
   logic [TIME_W-1:0]    req_now_time;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [STATE_W-1:0]   rsp_new_state;
   logic                 rsp_bad_transition;
   logic                 rsp_step_valid;
   logic [STEP_W-1:0]    rsp_step_kind;
   logic [TIME_W-1:0]    rsp_step_latency;
   logic                 rsp_total_valid;
   logic [TIME_W-1:0]    rsp_total_latency;

   slot_lifecycle_scoreboard tracker = new();

   bit steady;             // suppress idling on both channels
   bit hold_off_request;   // ask the receiver for one long hold-off

   // Flows in flight: each lane walks one transaction through a slot.
   bit [5:0]          lane_steps [LANES][$];
   bit [SLOT_W-1:0]   lane_slot  [LANES];
   bit [TIME_W-1:0]   now_ns;

   transaction_state_tracker dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_slot           (req_slot),
      .req_packet_kind    (req_packet_kind),
      .req_stage          (req_stage),
      .req_now_time       (req_now_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_new_state      (rsp_new_state),
      .rsp_bad_transition (rsp_bad_transition),
      .rsp_step_valid     (rsp_step_valid),
      .rsp_step_kind      (rsp_step_kind),
      .rsp_step_latency   (rsp_step_latency),
      .rsp_total_valid    (rsp_total_valid),
      .rsp_total_latency  (rsp_total_latency)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one item, optionally after a random gap, and hold it until accepted.
   // Enter and leave right after a rising edge.
   task automatic send_item(input bit [SLOT_W-1:0] slot, input bit [2:0] kind,
                            input bit [2:0] stage, input bit [TIME_W-1:0] stamp);
      int unsigned gap;
      gap = 0;
      while (!steady && gap < 24 && $urandom_range(0, 99) < IDLE_PCT) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_slot        <= slot;
      req_packet_kind <= kind;
      req_stage       <= stage;
      req_now_time    <= stamp;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.take_event(slot, kind, stage, stamp);
   endtask

   // Drop valid and wait until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_outcomes.size() != 0);
   endtask

   function automatic bit [5:0] code_of(bit [2:0] kind, bit [2:0] stage);
      return {kind, stage};
   endfunction

   // Load a well-formed transaction into a lane, with optional acks and rnr detours.
   function automatic void plan_flow(int unsigned lane, int unsigned which);
      case (which)
         0: begin  // pull, initiator side
            lane_steps[lane].push_back(code_of(PK_PULL_REQ, SG_ULP_RX));
            if ($urandom_range(0, 2) == 0)
               lane_steps[lane].push_back(code_of(PK_PULL_REQ, SG_NET_ACK_RX));
            lane_steps[lane].push_back(code_of(PK_PULL_REQ, SG_NET_TX));
            lane_steps[lane].push_back(code_of(PK_PULL_DATA, SG_NET_RX));
            lane_steps[lane].push_back(code_of(PK_PULL_DATA, SG_ULP_TX));
         end
         1: begin  // pull, target side
            lane_steps[lane].push_back(code_of(PK_PULL_REQ, SG_NET_RX));
            if ($urandom_range(0, 2) == 0)
               lane_steps[lane].push_back(code_of(PK_PULL_REQ, SG_ULP_RNR_RX));
            lane_steps[lane].push_back(code_of(PK_PULL_REQ, SG_ULP_TX));
            if ($urandom_range(0, 3) == 0) begin
               lane_steps[lane].push_back(code_of(PK_PULL_REQ, SG_ULP_RNR_RX));
               lane_steps[lane].push_back(code_of(PK_PULL_REQ, SG_ULP_TX));
            end
            lane_steps[lane].push_back(code_of(PK_PULL_REQ, SG_ULP_ACK_RX));
            lane_steps[lane].push_back(code_of(PK_PULL_DATA, SG_ULP_RX));
            lane_steps[lane].push_back(code_of(PK_PULL_DATA, SG_NET_TX));
            lane_steps[lane].push_back(code_of(PK_PULL_DATA, SG_NET_ACK_RX));
         end
         2: begin  // solicited push, initiator side
            lane_steps[lane].push_back(code_of(PK_PUSH_REQ, SG_ULP_RX));
            lane_steps[lane].push_back(code_of(PK_PUSH_REQ, SG_NET_TX));
            if ($urandom_range(0, 2) == 0)
               lane_steps[lane].push_back(code_of(PK_PUSH_REQ, SG_NET_ACK_RX));
            lane_steps[lane].push_back(code_of(PK_GRANT, SG_NET_RX));
            lane_steps[lane].push_back(code_of(PK_SOL_DATA, SG_NET_TX));
            lane_steps[lane].push_back(code_of(PK_SOL_DATA, SG_NET_ACK_RX));
            lane_steps[lane].push_back(code_of(PK_SOL_DATA, SG_ULP_CMPL_TX));
         end
         3: begin  // solicited push, target side
            lane_steps[lane].push_back(code_of(PK_PUSH_REQ, SG_NET_RX));
            lane_steps[lane].push_back(code_of(PK_GRANT, SG_NET_TX));
            if ($urandom_range(0, 2) == 0)
               lane_steps[lane].push_back(code_of(PK_GRANT, SG_NET_ACK_RX));
            lane_steps[lane].push_back(code_of(PK_SOL_DATA, SG_NET_RX));
            if ($urandom_range(0, 2) == 0)
               lane_steps[lane].push_back(code_of(PK_SOL_DATA, SG_ULP_RNR_RX));
            lane_steps[lane].push_back(code_of(PK_SOL_DATA, SG_ULP_TX));
            if ($urandom_range(0, 3) == 0) begin
               lane_steps[lane].push_back(code_of(PK_SOL_DATA, SG_ULP_RNR_RX));
               lane_steps[lane].push_back(code_of(PK_SOL_DATA, SG_ULP_TX));
            end
            lane_steps[lane].push_back(code_of(PK_SOL_DATA, SG_ULP_ACK_RX));
         end
         4: begin  // unsolicited, initiator side
            lane_steps[lane].push_back(code_of(PK_UNSOL_DATA, SG_ULP_RX));
            lane_steps[lane].push_back(code_of(PK_UNSOL_DATA, SG_NET_TX));
            lane_steps[lane].push_back(code_of(PK_UNSOL_DATA, SG_NET_ACK_RX));
            lane_steps[lane].push_back(code_of(PK_UNSOL_DATA, SG_ULP_CMPL_TX));
         end
         5: begin  // unsolicited, target side
            lane_steps[lane].push_back(code_of(PK_UNSOL_DATA, SG_NET_RX));
            if ($urandom_range(0, 2) == 0)
               lane_steps[lane].push_back(code_of(PK_UNSOL_DATA, SG_ULP_RNR_RX));
            lane_steps[lane].push_back(code_of(PK_UNSOL_DATA, SG_ULP_TX));
            if ($urandom_range(0, 3) == 0) begin
               lane_steps[lane].push_back(code_of(PK_UNSOL_DATA, SG_ULP_RNR_RX));
               lane_steps[lane].push_back(code_of(PK_UNSOL_DATA, SG_ULP_TX));
            end
            lane_steps[lane].push_back(code_of(PK_UNSOL_DATA, SG_ULP_ACK_RX));
         end
         default: lane_steps[lane].push_back(code_of(PK_RESYNC, SG_NET_RX));
      endcase
   endfunction

   // Pick the next random item: mostly the next step of some flow, else noise
   // that may land on a live slot and break its flow.
   task automatic pick_random(output bit [SLOT_W-1:0] slot, output bit [2:0] kind,
                              output bit [2:0] stage);
      int unsigned lane;
      bit [5:0]    code;
      lane = $urandom_range(0, LANES - 1);
      if ($urandom_range(0, 99) < 80) begin
         if (lane_steps[lane].size() == 0) begin
            lane_slot[lane] = $urandom_range(0, SLOTS - 1);
            plan_flow(lane, $urandom_range(0, 6));
         end
         code = lane_steps[lane].pop_front();
         slot = lane_slot[lane];
         {kind, stage} = code;
      end else begin
         kind  = $urandom_range(0, 7);
         stage = $urandom_range(0, 7);
         slot  = $urandom_range(0, 1) ? lane_slot[lane] : SLOT_W'($urandom_range(0, SLOTS - 1));
      end
   endtask

   // Stimulus: reset, directed walks through four flows and corners, then random flows.
   initial begin
      bit [SLOT_W-1:0] slot;
      bit [2:0]        kind;
      bit [2:0]        stage;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_slot        = '0;
      req_packet_kind = PK_PULL_REQ;
      req_stage       = SG_ULP_RX;
      req_now_time    = '0;
      steady          = 1'b0;
      hold_off_request = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Pull initiator from time zero, with a request ack and a late illegal step.
      send_item(10'd0, PK_PULL_REQ,  SG_ULP_RX,     48'd0);
      send_item(10'd0, PK_PULL_REQ,  SG_NET_ACK_RX, 48'd5);
      send_item(10'd0, PK_PULL_REQ,  SG_NET_TX,     48'd10);
      send_item(10'd0, PK_PULL_DATA, SG_NET_RX,     48'd25);
      send_item(10'd0, PK_PULL_DATA, SG_ULP_TX,     48'd40);
      send_item(10'd0, PK_PULL_DATA, SG_NET_TX,     48'd41);
      // Pull target on the top slot, latencies wrapping past the time limit.
      send_item(10'h3FF, PK_PULL_REQ,  SG_NET_RX,     T_MAX - 48'd15);
      send_item(10'h3FF, PK_PULL_REQ,  SG_ULP_RNR_RX, T_MAX);
      send_item(10'h3FF, PK_PULL_REQ,  SG_ULP_TX,     48'd6);
      send_item(10'h3FF, PK_PULL_REQ,  SG_ULP_ACK_RX, 48'd9);
      send_item(10'h3FF, PK_PULL_DATA, SG_ULP_RX,     48'd12);
      send_item(10'h3FF, PK_PULL_DATA, SG_NET_TX,     48'd20);
      send_item(10'h3FF, PK_PULL_DATA, SG_NET_ACK_RX, 48'd33);
      // Solicited push initiator with a grant ack in the middle.
      send_item(10'h2AA, PK_PUSH_REQ, SG_ULP_RX,      48'hAAAA_AAAA_AAAA);
      send_item(10'h2AA, PK_PUSH_REQ, SG_NET_TX,      48'hAAAA_AAAA_AAB0);
      send_item(10'h2AA, PK_GRANT,    SG_NET_RX,      48'hAAAA_AAAA_AAC4);
      send_item(10'h2AA, PK_GRANT,    SG_NET_ACK_RX,  48'hAAAA_AAAA_AAC8);
      send_item(10'h2AA, PK_SOL_DATA, SG_NET_TX,      48'hAAAA_AAAA_AAE0);
      send_item(10'h2AA, PK_SOL_DATA, SG_NET_ACK_RX,  48'hAAAA_AAAA_AB00);
      send_item(10'h2AA, PK_SOL_DATA, SG_ULP_CMPL_TX, 48'hFFFF_FFFF_FFFF);
      // Unsolicited target with rnr, then resync, the other kind and a pair with no rule.
      send_item(10'h155, PK_UNSOL_DATA, SG_NET_RX,     48'h5555_5555_5555);
      send_item(10'h155, PK_UNSOL_DATA, SG_ULP_RNR_RX, 48'h5555_5555_5560);
      send_item(10'h155, PK_UNSOL_DATA, SG_ULP_TX,     48'h5555_5555_5570);
      send_item(10'h155, PK_RESYNC,     SG_NET_RX,     48'h5555_5555_5580);
      send_item(10'h155, PK_OTHER,      SG_ULP_RX,     48'h5555_5555_5590);
      send_item(10'h155, PK_RESYNC,     SG_ULP_RX,     48'h5555_5555_55A0);

      now_ns = {$urandom, $urandom};
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 200) hold_off_request = 1'b1;   // let the block fill and stall
         if (i == 500) drain_results();
         steady = (i >= 700 && i < 900);
         if ($urandom_range(0, 49) == 0) now_ns = TIME_W'({$urandom, $urandom});
         else now_ns += $urandom_range(0, 40);
         pick_random(slot, kind, stage);
         send_item(slot, kind, stage, now_ns);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_outcomes.size() != 0);
      // Give any stray result time to show up.
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_outcomes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Result side: check each accepted item, then choose ready for the next cycle.
   initial begin
      outcome_t    seen;
      int unsigned hold_left;
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            seen.new_state      = rsp_new_state;
            seen.bad_transition = rsp_bad_transition;
            seen.step_valid     = rsp_step_valid;
            seen.step_kind      = rsp_step_kind;
            seen.step_latency   = rsp_step_latency;
            seen.total_valid    = rsp_total_valid;
            seen.total_latency  = rsp_total_latency;
            tracker.check_outcome(seen);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: end the run when neither channel moves an item for too long.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/tst_pkg.sv
design/tst_ctrl.sv
design/tst_datapath.sv
design/transaction_state_tracker.sv
design/tst_checker.sv
sim/tb_transaction_state_tracker.sv
